@@ rtl/core/rusi_pkg.sv @@
package rusi_pkg;

    // Defaults for the coordinate format (signed fixed point)
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Minimum ray parameter register
    localparam int EPS_WIDTH = 16;
    localparam int EPS_RESET = 66;

    // Multiplier digit consumed by each multiply cell
    localparam int MUL_DIGIT = 16;

endpackage

@@ rtl/core/rusi_mul_cell.sv @@
// One digit of a pipelined unsigned multiply: add a * digit K of b into the sum.
module rusi_mul_cell
    import rusi_pkg::*;
#(
    parameter int AW    = 64,
    parameter int BW    = 64,
    parameter int DIG   = MUL_DIGIT,
    parameter int K     = 0,
    parameter int PRW   = 128,
    parameter int SIDEW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [AW-1:0]    in_a,
    input  logic [BW-1:0]    in_b,
    input  logic [PRW-1:0]   in_acc,
    input  logic [SIDEW-1:0] in_side,
    output logic             out_vld,
    output logic [AW-1:0]    out_a,
    output logic [BW-1:0]    out_b,
    output logic [PRW-1:0]   out_acc,
    output logic [SIDEW-1:0] out_side
);

    localparam int SH = K * DIG;

    logic             vld_reg;
    logic [AW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [PRW-1:0]   acc_reg;
    logic [SIDEW-1:0] side_reg;

    logic [AW+DIG-1:0] part_next;
    logic [PRW-1:0]    acc_next;

    assign part_next = in_a * in_b[SH +: DIG];
    assign acc_next  = in_acc + (PRW'(part_next) << SH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= in_a;
            b_reg    <= in_b;
            acc_reg  <= acc_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_a    = a_reg;
    assign out_b    = b_reg;
    assign out_acc  = acc_reg;
    assign out_side = side_reg;

endmodule

@@ rtl/core/rusi_sqrt_cell.sv @@
// One root bit of a digit-by-digit integer square root.
// Remainder holds x - root^2; try setting bit J of the root.
module rusi_sqrt_cell
    import rusi_pkg::*;
#(
    parameter int J     = 0,
    parameter int XW    = 129,
    parameter int QW    = 65,
    parameter int SIDEW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [XW-1:0]    in_rem,
    input  logic [QW-1:0]    in_root,
    input  logic [SIDEW-1:0] in_side,
    output logic             out_vld,
    output logic [XW-1:0]    out_rem,
    output logic [QW-1:0]    out_root,
    output logic [SIDEW-1:0] out_side
);

    logic             vld_reg;
    logic [XW-1:0]    rem_reg;
    logic [QW-1:0]    root_reg;
    logic [SIDEW-1:0] side_reg;

    logic [XW+1:0] trial_next;
    logic          take_next;
    logic [XW-1:0] rem_next;
    logic [QW-1:0] root_next;

    always_comb
    begin
        trial_next = ((XW+2)'(in_root) << (J + 1)) + ((XW+2)'(1) << (2 * J));
        take_next  = ((XW+2)'(in_rem) >= trial_next);
        rem_next   = in_rem;
        root_next  = in_root;
        if (take_next)
        begin
            rem_next     = in_rem - trial_next[XW-1:0];
            root_next[J] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_side = side_reg;

endmodule

@@ rtl/core/rusi_div_cell.sv @@
// One quotient bit of a restoring divide: subtract divisor << I when it fits.
module rusi_div_cell
    import rusi_pkg::*;
#(
    parameter int I     = 0,
    parameter int RW    = 114,
    parameter int DVW   = 64,
    parameter int QW    = 31,
    parameter int SIDEW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [RW-1:0]    in_rem,
    input  logic [DVW-1:0]   in_dvs,
    input  logic [QW-1:0]    in_quo,
    input  logic [SIDEW-1:0] in_side,
    output logic             out_vld,
    output logic [RW-1:0]    out_rem,
    output logic [DVW-1:0]   out_dvs,
    output logic [QW-1:0]    out_quo,
    output logic [SIDEW-1:0] out_side
);

    logic             vld_reg;
    logic [RW-1:0]    rem_reg;
    logic [DVW-1:0]   dvs_reg;
    logic [QW-1:0]    quo_reg;
    logic [SIDEW-1:0] side_reg;

    logic [RW-1:0] sub_next;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] quo_next;

    always_comb
    begin
        sub_next = RW'(in_dvs) << I;
        rem_next = in_rem;
        quo_next = in_quo;
        if (in_rem >= sub_next)
        begin
            rem_next    = in_rem - sub_next;
            quo_next[I] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dvs_reg  <= in_dvs;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_dvs  = dvs_reg;
    assign out_quo  = quo_reg;
    assign out_side = side_reg;

endmodule

@@ rtl/core/ray_unit_sphere_intersect.sv @@
// Ray against the unit sphere at the origin, fixed point, fully pipelined.
//
// Input stream: one beat per ray, s_axis_tdata holds origin x/y/z then direction
// x/y/z, each COORD_WIDTH bits signed with FRAC_BITS fraction bits.
// Output stream: one beat per ray, same order as the input. m_axis_tuser is the
// hit flag; m_axis_tdata holds t, the hit point and the normal. A miss gives an
// all-zero beat with tuser low.
// Configuration: cfg_wr_en/cfg_wr_data load epsilon, the smallest accepted t.
// Write it only while no ray is in flight.
//
// Throughput: one ray per cycle while the skid register is empty. The pipeline depth
// is set mainly by the square-root chain (one root bit per cell) and the divide
// chain (one t bit per cell), with four 16-bit digit cells for the wide products.
// Reset clears all valid flags and loads epsilon with its default of 66.
// When the receiver stalls, a skid register catches the beat leaving the
// pipeline; s_axis_tready drops only once that skid register is occupied.
module ray_unit_sphere_intersect
    import rusi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wr_en,
    input  logic [EPS_WIDTH-1:0]                      cfg_wr_data,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // t_hit, point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
    output logic [((7*COORD_WIDTH-1+7)/8)*8-1:0]      m_axis_tdata,
    // hit
    output logic                                      m_axis_tuser
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;              // squares, dot products, A
    localparam int BW   = 2 * W + 2;          // signed B and C
    localparam int PRW  = 4 * W;              // B*B and A*|C|
    localparam int DW   = 4 * W + 2;          // signed discriminant
    localparam int XW   = DW - 1;             // non-negative radicand
    localparam int SW   = 2 * W + 1;          // square root
    localparam int NW   = 2 * W + 3;          // signed root numerators
    localparam int RW   = 3 * W + F + 2;      // scaled numerator, divide remainder
    localparam int TW   = W - 1;              // t
    localparam int NDIG = (PW + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int MBW  = NDIG * MUL_DIGIT;
    localparam int OUTW = ((7 * W - 1 + 7) / 8) * 8;

    typedef struct packed {
        logic                 miss;
        logic                 tsat;
        logic signed [BW-1:0] b;
        logic [PW-1:0]        a;
        logic [2:0][W-1:0]    o;
        logic [2:0][W-1:0]    d;
    } side_t;

    typedef struct packed {
        logic              hit;
        logic [TW-1:0]     t;
        logic [2:0][W-1:0] p;
    } beat_t;

    localparam int SIDEW = $bits(side_t);

    // Pipeline advances whenever the skid register is free
    logic skid_vld_reg;
    logic en;
    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    // ---------------- epsilon register ----------------
    logic [EPS_WIDTH-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_WIDTH'(EPS_RESET);
        end
        else if (cfg_wr_en)
        begin
            eps_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage 1: per-axis products ----------------
    logic signed [W-1:0]  in_o [3];
    logic signed [W-1:0]  in_d [3];
    logic                 v1_reg;
    logic signed [PW-1:0] dd_reg [3];
    logic signed [PW-1:0] do_reg [3];
    logic signed [PW-1:0] oo_reg [3];
    logic [2:0][W-1:0]    o1_reg;
    logic [2:0][W-1:0]    d1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_o[i] = $signed(s_axis_tdata[i*W +: W]);
            in_d[i] = $signed(s_axis_tdata[(3+i)*W +: W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dd_reg[i] <= in_d[i] * in_d[i];
                do_reg[i] <= in_d[i] * in_o[i];
                oo_reg[i] <= in_o[i] * in_o[i];
                o1_reg[i] <= in_o[i];
                d1_reg[i] <= in_d[i];
            end
        end
    end

    // ---------------- stage 2: A = d.d, B = d.o, C = o.o - 1 ----------------
    logic                 v2_reg;
    side_t                s2_next;
    side_t                s2_reg;
    logic signed [BW-1:0] c2_next;
    logic signed [BW-1:0] c2_reg;

    always_comb
    begin
        s2_next.miss = 1'b0;
        s2_next.tsat = 1'b0;
        s2_next.a    = $unsigned(dd_reg[0]) + $unsigned(dd_reg[1]) + $unsigned(dd_reg[2]);
        s2_next.b    = BW'(do_reg[0]) + BW'(do_reg[1]) + BW'(do_reg[2]);
        s2_next.o    = o1_reg;
        s2_next.d    = d1_reg;
        c2_next      = BW'(oo_reg[0]) + BW'(oo_reg[1]) + BW'(oo_reg[2])
                       - (BW'(1) << (2 * F));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
            c2_reg <= c2_next;
        end
    end

    // ---------------- stage 3: magnitudes, zero-direction check ----------------
    logic          v3_reg;
    side_t         s3_next;
    side_t         s3_reg;
    logic [PW-1:0] bmag3_reg;
    logic [PW-1:0] cmag3_reg;
    logic          csign3_reg;

    always_comb
    begin
        s3_next      = s2_reg;
        s3_next.miss = (s2_reg.a == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg     <= s3_next;
            bmag3_reg  <= s2_reg.b[BW-1] ? PW'(-s2_reg.b) : PW'(s2_reg.b);
            cmag3_reg  <= c2_reg[BW-1] ? PW'(-c2_reg) : PW'(c2_reg);
            csign3_reg <= c2_reg[BW-1];
        end
    end

    // ---------------- multiply chains: A*|C| and B*B ----------------
    logic             mac_vld  [0:NDIG];
    logic [PW-1:0]    mac_a    [0:NDIG];
    logic [MBW-1:0]   mac_b    [0:NDIG];
    logic [PRW-1:0]   mac_acc  [0:NDIG];
    side_t            mac_side [0:NDIG];
    logic             mbb_vld  [0:NDIG];
    logic [PW-1:0]    mbb_a    [0:NDIG];
    logic [MBW-1:0]   mbb_b    [0:NDIG];
    logic [PRW-1:0]   mbb_acc  [0:NDIG];
    logic [0:0]       mbb_side [0:NDIG];

    assign mac_vld[0]  = v3_reg;
    assign mac_a[0]    = s3_reg.a;
    assign mac_b[0]    = MBW'(cmag3_reg);
    assign mac_acc[0]  = '0;
    assign mac_side[0] = s3_reg;
    assign mbb_vld[0]  = v3_reg;
    assign mbb_a[0]    = bmag3_reg;
    assign mbb_b[0]    = MBW'(bmag3_reg);
    assign mbb_acc[0]  = '0;
    assign mbb_side[0] = csign3_reg;

    for (genvar k = 0; k < NDIG; k++)
    begin : g_mul
        rusi_mul_cell #(
            .AW(PW), .BW(MBW), .DIG(MUL_DIGIT), .K(k), .PRW(PRW), .SIDEW(SIDEW)
        ) u_ac (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_vld(mac_vld[k]), .in_a(mac_a[k]), .in_b(mac_b[k]),
            .in_acc(mac_acc[k]), .in_side(mac_side[k]),
            .out_vld(mac_vld[k+1]), .out_a(mac_a[k+1]), .out_b(mac_b[k+1]),
            .out_acc(mac_acc[k+1]), .out_side(mac_side[k+1])
        );
        rusi_mul_cell #(
            .AW(PW), .BW(MBW), .DIG(MUL_DIGIT), .K(k), .PRW(PRW), .SIDEW(1)
        ) u_bb (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_vld(mbb_vld[k]), .in_a(mbb_a[k]), .in_b(mbb_b[k]),
            .in_acc(mbb_acc[k]), .in_side(mbb_side[k]),
            .out_vld(mbb_vld[k+1]), .out_a(mbb_a[k+1]), .out_b(mbb_b[k+1]),
            .out_acc(mbb_acc[k+1]), .out_side(mbb_side[k+1])
        );
    end

    // ---------------- stage D: discriminant B*B - A*C ----------------
    logic                 vd_reg;
    logic signed [DW-1:0] disc_next;
    side_t                sd_next;
    side_t                sd_reg;
    logic [XW-1:0]        xd_reg;

    always_comb
    begin
        if (mbb_side[NDIG][0])
        begin
            disc_next = $signed(DW'(mbb_acc[NDIG])) + $signed(DW'(mac_acc[NDIG]));
        end
        else
        begin
            disc_next = $signed(DW'(mbb_acc[NDIG])) - $signed(DW'(mac_acc[NDIG]));
        end
        sd_next      = mac_side[NDIG];
        sd_next.miss = mac_side[NDIG].miss | disc_next[DW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg <= sd_next;
            // negative discriminant is a miss; feed zero to the root chain
            xd_reg <= disc_next[DW-1] ? '0 : disc_next[XW-1:0];
        end
    end

    // ---------------- square-root chain, one root bit per cell ----------------
    logic          sq_vld  [0:SW];
    logic [XW-1:0] sq_rem  [0:SW];
    logic [SW-1:0] sq_root [0:SW];
    side_t         sq_side [0:SW];

    assign sq_vld[0]  = vd_reg;
    assign sq_rem[0]  = xd_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = sd_reg;

    for (genvar k = 0; k < SW; k++)
    begin : g_sqrt
        rusi_sqrt_cell #(
            .J(SW - 1 - k), .XW(XW), .QW(SW), .SIDEW(SIDEW)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_vld(sq_vld[k]), .in_rem(sq_rem[k]), .in_root(sq_root[k]),
            .in_side(sq_side[k]),
            .out_vld(sq_vld[k+1]), .out_rem(sq_rem[k+1]), .out_root(sq_root[k+1]),
            .out_side(sq_side[k+1])
        );
    end

    // ---------------- stage N: root numerators, epsilon threshold ----------------
    logic                        vn_reg;
    logic signed [NW-1:0]        nb_next;
    logic signed [NW-1:0]        s_ext;
    logic [EPS_WIDTH+PW-1:0]     thr_prod;
    logic signed [NW-1:0]        n0_reg;
    logic signed [NW-1:0]        n1_reg;
    logic [RW-1:0]               thr_reg;
    side_t                       sn_reg;

    assign nb_next  = -NW'(sq_side[SW].b);
    assign s_ext    = $signed(NW'(sq_root[SW]));
    assign thr_prod = eps_reg * sq_side[SW].a;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg  <= nb_next - s_ext;
            n1_reg  <= nb_next + s_ext;
            thr_reg <= RW'(thr_prod);
            sn_reg  <= sq_side[SW];
        end
    end

    // ---------------- stage P: pick the nearest root at or beyond epsilon ----------------
    logic          vp_reg;
    logic [RW-1:0] m0_next;
    logic [RW-1:0] m1_next;
    logic          ok0_next;
    logic          ok1_next;
    logic [RW-1:0] mp_reg;
    side_t         sp_next;
    side_t         sp_reg;

    always_comb
    begin
        m0_next      = RW'($unsigned(n0_reg)) << F;
        m1_next      = RW'($unsigned(n1_reg)) << F;
        ok0_next     = !n0_reg[NW-1] && (m0_next >= thr_reg);
        ok1_next     = !n1_reg[NW-1] && (m1_next >= thr_reg);
        sp_next      = sn_reg;
        sp_next.miss = sn_reg.miss | !(ok0_next | ok1_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_reg <= ok0_next ? m0_next : m1_next;
            sp_reg <= sp_next;
        end
    end

    // ---------------- stage Q: saturation check on t ----------------
    logic          vq_reg;
    logic [RW-1:0] mq_reg;
    side_t         sq_next;
    side_t         sq_reg;

    always_comb
    begin
        sq_next      = sp_reg;
        sq_next.tsat = (mp_reg >= (RW'(sp_reg.a) << TW));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mq_reg <= mp_reg;
            sq_reg <= sq_next;
        end
    end

    // ---------------- divide chain, one t bit per cell ----------------
    logic          dv_vld  [0:TW];
    logic [RW-1:0] dv_rem  [0:TW];
    logic [PW-1:0] dv_dvs  [0:TW];
    logic [TW-1:0] dv_quo  [0:TW];
    side_t         dv_side [0:TW];

    assign dv_vld[0]  = vq_reg;
    assign dv_rem[0]  = mq_reg;
    assign dv_dvs[0]  = sq_reg.a;
    assign dv_quo[0]  = '0;
    assign dv_side[0] = sq_reg;

    for (genvar k = 0; k < TW; k++)
    begin : g_div
        rusi_div_cell #(
            .I(TW - 1 - k), .RW(RW), .DVW(PW), .QW(TW), .SIDEW(SIDEW)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_vld(dv_vld[k]), .in_rem(dv_rem[k]), .in_dvs(dv_dvs[k]),
            .in_quo(dv_quo[k]), .in_side(dv_side[k]),
            .out_vld(dv_vld[k+1]), .out_rem(dv_rem[k+1]), .out_dvs(dv_dvs[k+1]),
            .out_quo(dv_quo[k+1]), .out_side(dv_side[k+1])
        );
    end

    // ---------------- stage T: clamp t, d * t ----------------
    logic                 vt_reg;
    logic [TW-1:0]        tb_next;
    logic [TW-1:0]        tb_reg;
    logic signed [PW-1:0] prod_reg [3];
    side_t                st_reg;

    assign tb_next = dv_side[TW].tsat ? '1 : dv_quo[TW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= $signed(dv_side[TW].d[i]) * $signed({1'b0, tb_next});
            end
            tb_reg <= tb_next;
            st_reg <= dv_side[TW];
        end
    end

    // ---------------- stage O: point = o + floor(d*t), saturate ----------------
    localparam logic signed [2*W:0] PMAX = $signed({{(W+2){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [2*W:0] PMIN = $signed({{(W+2){1'b1}}, {(W-1){1'b0}}});

    logic                 vo_reg;
    logic signed [PW-1:0] sh_next  [3];
    logic signed [2*W:0]  sum_next [3];
    beat_t                beat_next;
    beat_t                beat_reg;

    always_comb
    begin
        beat_next.hit = !st_reg.miss;
        beat_next.t   = st_reg.miss ? '0 : tb_reg;
        for (int i = 0; i < 3; i++)
        begin
            sh_next[i]  = prod_reg[i] >>> F;
            sum_next[i] = (2*W+1)'(sh_next[i]) + (2*W+1)'($signed(st_reg.o[i]));
            if (st_reg.miss)
            begin
                beat_next.p[i] = '0;
            end
            else if (sum_next[i] > PMAX)
            begin
                beat_next.p[i] = PMAX[W-1:0];
            end
            else if (sum_next[i] < PMIN)
            begin
                beat_next.p[i] = PMIN[W-1:0];
            end
            else
            begin
                beat_next.p[i] = sum_next[i][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    // ---------------- stage valid flags ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vd_reg <= 1'b0;
            vn_reg <= 1'b0;
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
            vt_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vd_reg <= mac_vld[NDIG] & mbb_vld[NDIG];
            vn_reg <= sq_vld[SW];
            vp_reg <= vn_reg;
            vq_reg <= vp_reg;
            vt_reg <= dv_vld[TW];
            vo_reg <= vt_reg;
        end
    end

    // ---------------- output register with skid ----------------
    // The pipeline's last stage is overwritten on every advance, so its beat
    // goes either to the output register or, when that one is stalled, to skid.
    logic  out_vld_reg;
    beat_t out_reg;
    beat_t skid_reg;
    logic  take;

    assign take = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            out_vld_reg <= vo_reg;
        end
        else if (vo_reg)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (take)
        begin
            out_reg <= beat_reg;
        end
        else
        begin
            skid_reg <= beat_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_reg.hit;
    // normal equals the hit point on the unit sphere
    assign m_axis_tdata  = OUTW'({out_reg.p, out_reg.p, out_reg.t});

endmodule

@@ rtl/core/rusi_checker.sv @@
module rusi_checker
    import rusi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((7*COORD_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
    input logic                                 m_axis_tuser
);

    localparam int W = COORD_WIDTH;

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed or dropped");

    // A miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss beat with nonzero payload");

    // Normal equals hit point
    a_normal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4*W-1 +: 3*W] == m_axis_tdata[W-1 +: 3*W])
        else $error("normal differs from hit point");

    // Input backpressure only follows a stalled output beat
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

endmodule

bind ray_unit_sphere_intersect rusi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rusi_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);

@@ verif/ray_unit_sphere_intersect_tb.sv @@
`timescale 1ns / 100ps

module ray_unit_sphere_intersect_tb;
    import rusi_pkg::*;

    localparam int CW       = 32;
    localparam int FB       = 16;
    localparam int IN_W     = ((6*CW+7)/8)*8;
    localparam int OUT_W    = ((7*CW-1+7)/8)*8;
    localparam int LATENCY  = 110;
    localparam int SETTLE   = LATENCY + 20;
    localparam int LIMIT    = 2000000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    // Wide signed integer, enough for B*B - A*C of full-range coordinates
    typedef logic signed [199:0] wint;

    typedef struct packed {
        logic             hit;
        logic [OUT_W-1:0] beat;
    } hit_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [EPS_WIDTH-1:0] cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // t_hit, point_x/y/z, normal_x/y/z, pad
    logic                 m_axis_tuser;   // hit

    hit_result_t          pending_hits[$];
    logic [EPS_WIDTH-1:0] eps_model;
    int unsigned          error_count;
    int unsigned          cycle_count;
    int unsigned          rx_stall;
    bit                   no_idle;

    ray_unit_sphere_intersect u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Compute the expected beat for one ray with exact wide arithmetic.
    function automatic hit_result_t intersect_ray(input logic [IN_W-1:0] ray);
        hit_result_t res;
        wint o[3];
        wint d[3];
        wint a, b, c, disc, root, cand, num, thr, t, tw, p, eps_w;
        wint nroot[2];
        wint cmax, cmin;
        logic [CW-2:0] tb;
        logic [CW-1:0] pc;
        int pick;
        res = '0;
        a = 0;
        b = 0;
        c = 0;
        num = 0;
        pick = -1;
        eps_w = eps_model;
        cmax = 64'sh7FFF_FFFF;
        cmin = -64'sh8000_0000;
        for (int i = 0; i < 3; i++)
        begin
            o[i] = $signed(ray[CW*i +: CW]);
            d[i] = $signed(ray[CW*(i+3) +: CW]);
            a = a + d[i]*d[i];
            b = b + d[i]*o[i];
            c = c + o[i]*o[i];
        end
        c = c - (wint'(1) <<< (2*FB));
        // zero direction and negative discriminant are misses
        if (a == 0)
            return res;
        disc = b*b - a*c;
        if (disc < 0)
            return res;
        root = 0;
        for (int k = 70; k >= 0; k--)
        begin
            cand = root | (wint'(1) <<< k);
            if (cand*cand <= disc)
                root = cand;
        end
        nroot[0] = -b - root;
        nroot[1] = -b + root;
        thr = eps_w * a;
        // nearer root first, fall back to the far one (origin inside the sphere)
        for (int k = 0; k < 2; k++)
        begin
            if (pick < 0 && nroot[k] >= 0)
            begin
                num = nroot[k] <<< FB;
                if (num >= thr)
                    pick = k;
            end
        end
        if (pick < 0)
            return res;
        t = num / a;
        tb = (t > wint'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : t[CW-2:0];
        tw = tb;
        res.hit = 1'b1;
        res.beat[CW-2:0] = tb;
        for (int i = 0; i < 3; i++)
        begin
            p = o[i] + ((d[i]*tw) >>> FB);
            if (p > cmax)
                pc = 32'h7FFF_FFFF;
            else if (p < cmin)
                pc = 32'h8000_0000;
            else
                pc = p[CW-1:0];
            res.beat[CW-1 + CW*i +: CW]   = pc;
            res.beat[CW-1 + CW*(i+3) +: CW] = pc;
        end
        return res;
    endfunction

    // Drive one ray and hold it until the beat is taken.
    task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                            input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz);
        int gap;
        logic [IN_W-1:0] ray;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        ray = {dz, dy, dx, oz, oy, ox};
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ray;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_hits.push_back(intersect_ray(ray));
    endtask

    // Drop valid and let the pipe empty before touching epsilon.
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_epsilon(input logic [EPS_WIDTH-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        eps_model = value;
    endtask

    // Random origin within +-8, direction roughly toward the sphere.
    task automatic send_aimed_ray();
        logic signed [31:0] o[3];
        logic signed [31:0] d[3];
        int shift;
        shift = $urandom_range(0, 6);
        for (int i = 0; i < 3; i++)
        begin
            o[i] = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            d[i] = (-o[i] >>> shift) + ($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
        end
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    task automatic test_special_rays();
        send_ray(0, 0, -5*ONE, 0, 0, 0);                    // zero direction
        send_ray(0, 0, -5*ONE, 0, 0, ONE);                  // head-on
        send_ray(0, ONE, -5*ONE, 0, 0, ONE);                // tangent
        send_ray(0, 2*ONE, -5*ONE, 0, 0, ONE);              // clean miss
        send_ray(0, 0, 0, ONE, 0, 0);                       // origin at center
        send_ray(ONE/4, 0, ONE/2, 0, ONE, 0);               // inside, off center
        send_ray(0, 0, 5*ONE, 0, 0, ONE);                   // sphere behind
        send_ray(0, 0, -32'sd30000*ONE, 0, 0, 1);           // huge t, saturated
        send_ray(0, 0, -32'sd30000*ONE, 0, 0, ONE);         // far but in range
        send_ray(ONE, 0, 0, -ONE, 0, 0);                    // starting on surface
        send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0);
        send_ray(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 1, 0);
        send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1);
        send_ray(0, 0, -2*ONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_ray(0, 0, -2*ONE, 0, 0, 32'h7FFF_FFFF);
        send_ray(0, 0, -2*ONE, 0, 0, 1);
        drain_pipe();
    endtask

    // Try epsilon at both extremes with fixed rays on, inside and outside the sphere and random aimed rays.
    task automatic test_epsilon_limits();
        write_epsilon('0);
        send_ray(ONE, 0, 0, -ONE, 0, 0);
        send_ray(0, 0, 0, 0, ONE, 0);
        repeat (40) send_aimed_ray();
        drain_pipe();
        write_epsilon('1);
        send_ray(ONE, 0, 0, -ONE, 0, 0);
        send_ray(0, 0, -ONE - ONE/2, 0, 0, ONE);
        send_ray(0, 0, -3*ONE, 0, 0, ONE);
        repeat (40) send_aimed_ray();
        drain_pipe();
    endtask

    task automatic test_aimed_rays();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_epsilon((phase % 2) ? EPS_WIDTH'($urandom()) : EPS_WIDTH'($urandom_range(0, 200)));
            repeat (160) send_aimed_ray();
            drain_pipe();
        end
    endtask

    // Full-range noise: covers every input bit and saturation paths.
    task automatic test_noise_rays();
        write_epsilon(EPS_WIDTH'(EPS_RESET));
        repeat (250)
            send_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        repeat (100)
            send_ray($urandom(), $urandom(), $urandom(),
                     $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
        drain_pipe();
    endtask

    // Back-to-back beats on both sides, then back to random idling.
    task automatic test_full_rate();
        no_idle = 1;
        repeat (300) send_aimed_ray();
        no_idle = 0;
        repeat (100) send_aimed_ray();
        drain_pipe();
    endtask

    // Receiver: stall a random number of cycles per beat and check each one.
    always @(posedge clk)
    begin
        hit_result_t exp_hit;
        int unsigned stall;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            rx_stall <= (stall > 0) ? stall - 1 : 0;
            m_axis_tready <= (stall == 0);
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected beat tuser=%b tdata=%h", $time, m_axis_tuser,
                         m_axis_tdata);
                error_count = error_count + 1;
            end
            else
            begin
                exp_hit = pending_hits.pop_front();
                if (exp_hit.hit !== m_axis_tuser)
                begin
                    $display("%0t: hit expected %b actual %b", $time, exp_hit.hit, m_axis_tuser);
                    error_count = error_count + 1;
                end
                if (exp_hit.beat[CW-2:0] !== m_axis_tdata[CW-2:0])
                begin
                    $display("%0t: t_hit expected %h actual %h", $time, exp_hit.beat[CW-2:0],
                             m_axis_tdata[CW-2:0]);
                    error_count = error_count + 1;
                end
                for (int f = 0; f < 6; f++)
                begin
                    if (exp_hit.beat[CW-1 + CW*f +: CW] !== m_axis_tdata[CW-1 + CW*f +: CW])
                    begin
                        $display("%0t: %s_%s expected %h actual %h", $time,
                                 (f < 3) ? "point" : "normal", (f % 3 == 0) ? "x" :
                                 (f % 3 == 1) ? "y" : "z", exp_hit.beat[CW-1 + CW*f +: CW],
                                 m_axis_tdata[CW-1 + CW*f +: CW]);
                        error_count = error_count + 1;
                    end
                end
            end
        end
        else if (rx_stall > 0)
        begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Watchdog: end the run if the pipe hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        eps_model     = EPS_WIDTH'(EPS_RESET);
        error_count   = 0;
        cycle_count   = 0;
        rx_stall      = 0;
        no_idle       = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_rays();
        test_epsilon_limits();
        test_aimed_rays();
        test_noise_rays();
        test_full_rate();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
